@@ rtl/abbd_pkg.sv @@
package abbd_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               frame_last;
        logic [31:0]        now_ms;
    } in_word_t;

    typedef struct packed {
        logic        beat_active;
        logic        beat_now;
        logic [15:0] bpm;
        logic [30:0] envelope;
        logic [31:0] threshold;
    } out_word_t;

    localparam logic [2:0] REG_ATTACK   = 3'd0;
    localparam logic [2:0] REG_RELEASE  = 3'd1;
    localparam logic [2:0] REG_TMULT    = 3'd2;
    localparam logic [2:0] REG_TOFFSET  = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE = 3'd4;
    localparam logic [2:0] REG_IMIN     = 3'd5;
    localparam logic [2:0] REG_IMAX     = 3'd6;
    localparam logic [2:0] REG_TIMEOUT  = 3'd7;

    localparam int FRAC_BITS = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EDIV,
        ST_ENV,
        ST_HREAD,
        ST_HUPD,
        ST_ADIV,
        ST_THR,
        ST_BEAT,
        ST_IREAD,
        ST_IUPD,
        ST_TDIV,
        ST_OUT
    } state_t;

endpackage

@@ rtl/abbd_divider.sv @@
module abbd_divider #(
    parameter int NW = 46,
    parameter int DW = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle, restoring.
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/audio_beat_bpm_detector.sv @@
// Energy-envelope beat detector with tempo estimate.
// Input words (sample, frame_last, now_ms) arrive on in_valid/in_ready.
// A word that is not the end of a frame only adds its square into the
// frame accumulator, up to MAX_FRAME nonzero samples; it produces no output word.
// A frame-end word starts the evaluation sequence and yields one output
// word on out_valid/out_ready; a second division is added when a new beat
// interval enters the tempo window. The shared bit-serial divider computes
// the mean energy and the tempo; the history average is a reciprocal
// multiplication, sixteen bits of the reciprocal at a time.
// One word is worked on at a time; in_ready is low during evaluation.
// The finished word sits in an output register, so the next input word is
// taken while it waits for the receiver; a second frame end waits until
// the receiver has taken the earlier result.
// After reset the block sweeps the envelope history memory to zero, one
// entry per cycle, before accepting the first word.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while no frame end is evaluated; the block does not check it.
module audio_beat_bpm_detector #(
    parameter int HIST_DEPTH = 43,
    parameter int BPM_DEPTH  = 8,
    parameter int MAX_FRAME  = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  abbd_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output abbd_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int HW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int BW  = (BPM_DEPTH > 1) ? $clog2(BPM_DEPTH) : 1;
    localparam int NCW = $clog2(MAX_FRAME + 1);
    localparam int ICW = $clog2(BPM_DEPTH + 1);
    localparam int ISW = 16 + $clog2(BPM_DEPTH + 1);
    localparam int HSW = 40 + $clog2(HIST_DEPTH + 1);
    localparam int DNW = 40;
    localparam int DDW = (ISW > NCW) ? ISW : NCW;

    // The history average is floor(sum / HIST_DEPTH), taken as the sum times
    // a rounded-up reciprocal; this is exact for every sum below 2^HSW.
    localparam int RK  = HSW + $clog2(HIST_DEPTH);
    localparam int NCH = (HSW + 2 + 15) / 16;
    localparam int PW  = 16 * NCH;
    localparam int RMW = HSW + PW;
    localparam int RCW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [PW-1:0] RECIP =
        PW'(((64'd1 << RK) + 64'(HIST_DEPTH - 1)) / 64'(HIST_DEPTH));

    logic [15:0] attack_reg, release_reg, tmult_reg, debounce_reg;
    logic [15:0] imin_reg, imax_reg, timeout_reg;
    logic [23:0] toffset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg   <= 16'd32768;
            release_reg  <= 16'd3277;
            tmult_reg    <= 16'd6144;
            toffset_reg  <= 24'd500;
            debounce_reg <= 16'd200;
            imin_reg     <= 16'd300;
            imax_reg     <= 16'd2000;
            timeout_reg  <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abbd_pkg::REG_ATTACK:   attack_reg   <= cfg_data[15:0];
                abbd_pkg::REG_RELEASE:  release_reg  <= cfg_data[15:0];
                abbd_pkg::REG_TMULT:    tmult_reg    <= cfg_data[15:0];
                abbd_pkg::REG_TOFFSET:  toffset_reg  <= cfg_data;
                abbd_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data[15:0];
                abbd_pkg::REG_IMIN:     imin_reg     <= cfg_data[15:0];
                abbd_pkg::REG_IMAX:     imax_reg     <= cfg_data[15:0];
                abbd_pkg::REG_TIMEOUT:  timeout_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Memories.
    logic [39:0] hist_mem [HIST_DEPTH];
    logic [15:0] ival_mem [BPM_DEPTH];
    logic [39:0] hist_rd;
    logic [15:0] ival_rd;
    logic        hist_we, ival_we;
    logic [HW-1:0] hist_waddr;
    logic [39:0] hist_wdata;

    abbd_pkg::state_t state_reg, state_next;
    logic [39:0]   acc_reg, acc_next;
    logic [NCW-1:0] cnt_reg, cnt_next;
    logic [39:0]   env_reg, env_next;
    logic [HSW-1:0] hsum_reg, hsum_next;
    logic [HW-1:0] hpos_reg, hpos_next;
    logic [31:0]   lbt_reg, lbt_next;
    logic [ISW-1:0] isum_reg, isum_next;
    logic [ICW-1:0] icnt_reg, icnt_next;
    logic [BW-1:0] ipos_reg, ipos_next;
    logic [15:0]   tempo_reg, tempo_next;
    logic          flag_reg, flag_next;
    logic [39:0]   energy_reg, energy_next;
    logic [49:0]   thr_reg, thr_next;
    logic [31:0]   now_reg, now_next;
    logic          beat_reg, beat_next;
    logic [31:0]   ela_reg, ela_next;
    logic          ovalid_reg, ovalid_next;
    abbd_pkg::out_word_t odata_reg, odata_next;
    logic [RMW-1:0] rmul_reg, rmul_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;

    logic          div_start, div_busy;
    logic [DNW-1:0] div_num, div_quo;
    logic [DDW-1:0] div_den;

    abbd_divider #(.NW(DNW), .DW(DDW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_rd <= hist_mem[hpos_reg];
        if (ival_we)
            ival_mem[ipos_reg] <= ela_reg[15:0];
        ival_rd <= ival_mem[ipos_reg];
    end

    logic [15:0] mag;
    logic [39:0] diff;
    logic [55:0] prod;
    logic [15:0] rchunk;
    logic [HSW+15:0] rpart;
    logic [39:0] avg;
    logic [55:0] tprod;
    logic [31:0] ela_now;
    logic        in_ok;

    assign in_ready = ((state_reg == abbd_pkg::ST_IDLE) && !(in_data.frame_last && ovalid_reg))
                      || 1'b0;
    assign in_ok    = in_valid && in_ready;
    assign mag      = in_data.sample[15] ? 16'(-in_data.sample) : in_data.sample;
    assign diff     = (energy_reg > env_reg) ? energy_reg - env_reg : env_reg - energy_reg;
    assign prod     = diff * ((energy_reg > env_reg) ? attack_reg : release_reg);
    assign rchunk   = RECIP[16*rcnt_reg +: 16];
    assign rpart    = hsum_reg * rchunk;
    assign avg      = rmul_reg[RK +: 40];
    assign tprod    = avg * tmult_reg;
    assign ela_now  = now_reg - lbt_next;

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        env_next    = env_reg;
        hsum_next   = hsum_reg;
        hpos_next   = hpos_reg;
        lbt_next    = lbt_reg;
        isum_next   = isum_reg;
        icnt_next   = icnt_reg;
        ipos_next   = ipos_reg;
        tempo_next  = tempo_reg;
        flag_next   = flag_reg;
        energy_next = energy_reg;
        thr_next    = thr_reg;
        now_next    = now_reg;
        beat_next   = beat_reg;
        ela_next    = ela_reg;
        ovalid_next = ovalid_reg && !out_ready;
        odata_next  = odata_reg;
        rmul_next   = rmul_reg;
        rcnt_next   = rcnt_reg;
        hist_we     = 1'b0;
        hist_waddr  = hpos_reg;
        hist_wdata  = env_reg;
        ival_we     = 1'b0;
        div_start   = 1'b0;
        div_num     = DNW'(acc_reg);
        div_den     = DDW'(cnt_reg);
        case (state_reg)
            abbd_pkg::ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_wdata = '0;
                if (hpos_reg == HW'(HIST_DEPTH - 1))
                begin
                    hpos_next  = '0;
                    state_next = abbd_pkg::ST_IDLE;
                end
                else
                    hpos_next = hpos_reg + 1'b1;
            end
            abbd_pkg::ST_IDLE:
            begin
                if (in_ok)
                begin
                    if (mag != 16'd0 && cnt_reg < NCW'(MAX_FRAME))
                    begin
                        acc_next = acc_reg + 40'(mag) * 40'(mag);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (in_data.frame_last)
                    begin
                        now_next = in_data.now_ms;
                        state_next = abbd_pkg::ST_EDIV;
                        div_start = 1'b1;
                        div_num = DNW'(acc_next);
                        div_den = DDW'(cnt_next);
                        energy_next = (cnt_next == '0) ? 40'd0 : energy_reg;
                        beat_next = (cnt_next == '0);
                    end
                end
            end
            abbd_pkg::ST_EDIV:
            begin
                // beat_reg temporarily marks an empty frame here.
                if (!div_busy)
                begin
                    if (!beat_reg)
                        energy_next = 40'(div_quo << abbd_pkg::FRAC_BITS);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = abbd_pkg::ST_ENV;
                end
            end
            abbd_pkg::ST_ENV:
            begin
                if (energy_reg > env_reg)
                    env_next = env_reg + 40'(prod >> 16);
                else
                    env_next = env_reg - 40'(prod >> 16);
                state_next = abbd_pkg::ST_HREAD;
            end
            abbd_pkg::ST_HREAD:
                state_next = abbd_pkg::ST_HUPD;
            abbd_pkg::ST_HUPD:
            begin
                hsum_next = hsum_reg - HSW'(hist_rd) + HSW'(env_reg);
                hist_we   = 1'b1;
                hpos_next = (hpos_reg == HW'(HIST_DEPTH - 1)) ? '0 : hpos_reg + 1'b1;
                rmul_next = '0;
                rcnt_next = RCW'(NCH - 1);
                state_next = abbd_pkg::ST_ADIV;
            end
            abbd_pkg::ST_ADIV:
            begin
                // Sixteen bits of the reciprocal per cycle, most significant first.
                rmul_next = {rmul_reg[RMW-17:0], 16'd0} + RMW'(rpart);
                if (rcnt_reg == '0)
                    state_next = abbd_pkg::ST_THR;
                else
                    rcnt_next = rcnt_reg - 1'b1;
            end
            abbd_pkg::ST_THR:
            begin
                thr_next = 50'(tprod >> 12) + 50'({toffset_reg, 9'd0});
                ela_next = now_reg - lbt_reg;
                state_next = abbd_pkg::ST_BEAT;
            end
            abbd_pkg::ST_BEAT:
            begin
                beat_next = 1'b0;
                state_next = abbd_pkg::ST_OUT;
                if ({10'd0, env_reg} > thr_reg && ela_reg > {16'd0, debounce_reg})
                begin
                    beat_next = 1'b1;
                    lbt_next  = now_reg;
                    flag_next = 1'b1;
                    if (lbt_reg != 32'd0 && ela_reg >= {16'd0, imin_reg}
                        && ela_reg <= {16'd0, imax_reg})
                        state_next = abbd_pkg::ST_IREAD;
                end
                if (state_next == abbd_pkg::ST_OUT && flag_next
                    && ela_now > {16'd0, timeout_reg})
                    flag_next = 1'b0;
            end
            abbd_pkg::ST_IREAD:
                state_next = abbd_pkg::ST_IUPD;
            abbd_pkg::ST_IUPD:
            begin
                if (icnt_reg >= ICW'(BPM_DEPTH))
                    isum_next = isum_reg - ISW'(ival_rd) + ISW'(ela_reg[15:0]);
                else
                begin
                    icnt_next = icnt_reg + 1'b1;
                    isum_next = isum_reg + ISW'(ela_reg[15:0]);
                end
                ival_we   = 1'b1;
                ipos_next = (ipos_reg == BW'(BPM_DEPTH - 1)) ? '0 : ipos_reg + 1'b1;
                div_start = 1'b1;
                div_num   = DNW'(32'd60000 * 32'(icnt_next));
                div_den   = DDW'(isum_next);
                state_next = abbd_pkg::ST_TDIV;
            end
            abbd_pkg::ST_TDIV:
            begin
                if (!div_busy)
                begin
                    tempo_next = (isum_reg == '0) ? 16'd0 : div_quo[15:0];
                    state_next = abbd_pkg::ST_OUT;
                end
            end
            abbd_pkg::ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    odata_next.beat_active = flag_reg;
                    odata_next.beat_now    = beat_reg;
                    odata_next.bpm         = tempo_reg;
                    odata_next.envelope    = env_reg[39:9];
                    odata_next.threshold   = (thr_reg[49:41] != '0) ? 32'hFFFF_FFFF
                                             : thr_reg[40:9];
                    state_next = abbd_pkg::ST_IDLE;
                end
            end
            default: state_next = abbd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= abbd_pkg::ST_CLEAR;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            env_reg    <= '0;
            hsum_reg   <= '0;
            hpos_reg   <= '0;
            lbt_reg    <= '0;
            isum_reg   <= '0;
            icnt_reg   <= '0;
            ipos_reg   <= '0;
            tempo_reg  <= '0;
            flag_reg   <= 1'b0;
            beat_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            rcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            env_reg    <= env_next;
            hsum_reg   <= hsum_next;
            hpos_reg   <= hpos_next;
            lbt_reg    <= lbt_next;
            isum_reg   <= isum_next;
            icnt_reg   <= icnt_next;
            ipos_reg   <= ipos_next;
            tempo_reg  <= tempo_next;
            flag_reg   <= flag_next;
            beat_reg   <= beat_next;
            ovalid_reg <= ovalid_next;
            rcnt_reg   <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        thr_reg    <= thr_next;
        now_reg    <= now_next;
        ela_reg    <= ela_next;
        odata_reg  <= odata_next;
        rmul_reg   <= rmul_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int HIST_N     = 43;
    localparam int IVL_N      = 8;
    localparam int FRAME_CAP  = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int RAND_WORDS = 1650;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    abbd_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    abbd_pkg::out_word_t out_data;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [23:0]         cfg_data;

    audio_beat_bpm_detector dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Shadow of the block's settings and state.
    logic [15:0] k_attack, k_release, k_mult, k_debounce, k_imin, k_imax, k_timeout;
    logic [23:0] k_offset;
    logic [39:0] acc_energy;
    int unsigned frame_count;
    logic [39:0] env_q9;
    logic [39:0] env_ring [HIST_N];
    logic [45:0] env_ring_sum;
    int unsigned env_ring_pos;
    logic [31:0] prev_beat_ms;
    logic [15:0] ivl_ring [IVL_N];
    logic [31:0] ivl_sum;
    int unsigned ivl_count;
    int unsigned ivl_pos;
    logic [15:0] tempo_bpm;
    logic        flag_on;

    abbd_pkg::out_word_t frame_results [$];
    int          errors;
    int          mismatches;
    int          idle_cycles;
    bit          stim_done;
    bit          long_stall_req;
    bit          long_stall_done;

    task automatic shadow_reset();
        k_attack = 16'd32768; k_release = 16'd3277; k_mult = 16'd6144;
        k_offset = 24'd500; k_debounce = 16'd200; k_imin = 16'd300;
        k_imax = 16'd2000; k_timeout = 16'd100;
        acc_energy = '0; frame_count = 0; env_q9 = '0; env_ring_sum = '0;
        env_ring_pos = 0; prev_beat_ms = '0; ivl_sum = '0; ivl_count = 0;
        ivl_pos = 0; tempo_bpm = '0; flag_on = 1'b0;
        for (int i = 0; i < HIST_N; i++) env_ring[i] = '0;
        for (int i = 0; i < IVL_N; i++) ivl_ring[i] = '0;
    endtask

    // Advances the shadow by one word; returns 1 and the result at frame end.
    function automatic bit beat_frame_update(input abbd_pkg::in_word_t w,
                                             output abbd_pkg::out_word_t r);
        logic [15:0] raw;
        logic [16:0] mag;
        logic [63:0] energy, diff, avg, thr, thr_int;
        logic [31:0] elapsed;
        bit beat;
        raw = w.sample;
        beat = 1'b0;
        r = '0;
        if (raw != 0 && frame_count < FRAME_CAP)
        begin
            mag = raw[15] ? (17'h10000 - raw) : {1'b0, raw};
            acc_energy = acc_energy + 40'(mag) * 40'(mag);
            frame_count++;
        end
        if (!w.frame_last)
            return 1'b0;
        energy = (frame_count == 0) ? 64'd0 : ((64'(acc_energy) / frame_count) << 9);
        acc_energy = '0;
        frame_count = 0;
        if (energy > 64'(env_q9))
        begin
            diff = energy - env_q9;
            env_q9 = env_q9 + 40'((diff * k_attack) >> 16);
        end
        else
        begin
            diff = 64'(env_q9) - energy;
            env_q9 = env_q9 - 40'((diff * k_release) >> 16);
        end
        env_ring_sum = env_ring_sum - env_ring[env_ring_pos] + env_q9;
        env_ring[env_ring_pos] = env_q9;
        env_ring_pos = (env_ring_pos + 1 >= HIST_N) ? 0 : env_ring_pos + 1;
        avg = 64'(env_ring_sum) / HIST_N;
        thr = ((avg * k_mult) >> 12) + (64'(k_offset) << 9);
        elapsed = w.now_ms - prev_beat_ms;
        if (64'(env_q9) > thr && elapsed > k_debounce)
        begin
            if (prev_beat_ms != 0 && elapsed >= k_imin && elapsed <= k_imax)
            begin
                if (ivl_count >= IVL_N)
                    ivl_sum = ivl_sum - ivl_ring[ivl_pos];
                else
                    ivl_count++;
                ivl_ring[ivl_pos] = elapsed[15:0];
                ivl_sum = ivl_sum + elapsed;
                ivl_pos = (ivl_pos + 1 >= IVL_N) ? 0 : ivl_pos + 1;
                tempo_bpm = (ivl_sum == 0) ? 16'd0 : 16'((60000 * ivl_count) / ivl_sum);
            end
            prev_beat_ms = w.now_ms;
            flag_on = 1'b1;
            beat = 1'b1;
        end
        if (flag_on && (w.now_ms - prev_beat_ms) > k_timeout)
            flag_on = 1'b0;
        thr_int = thr >> 9;
        if (thr_int > 64'hFFFF_FFFF)
            thr_int = 64'hFFFF_FFFF;
        r.beat_active = flag_on;
        r.beat_now    = beat;
        r.bpm         = tempo_bpm;
        r.envelope    = env_q9[39:9];
        r.threshold   = thr_int[31:0];
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            abbd_pkg::REG_ATTACK:   k_attack   = val[15:0];
            abbd_pkg::REG_RELEASE:  k_release  = val[15:0];
            abbd_pkg::REG_TMULT:    k_mult     = val[15:0];
            abbd_pkg::REG_TOFFSET:  k_offset   = val;
            abbd_pkg::REG_DEBOUNCE: k_debounce = val[15:0];
            abbd_pkg::REG_IMIN:     k_imin     = val[15:0];
            abbd_pkg::REG_IMAX:     k_imax     = val[15:0];
            abbd_pkg::REG_TIMEOUT:  k_timeout  = val[15:0];
            default: ;
        endcase
    endtask

    // Waits for all results plus the latency of a frame still being evaluated.
    task automatic drain();
        while (frame_results.size() != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // Sends one word, with an occasional random gap if gap_ok; at frame end it queues the shadow's result.
    task automatic send_word(input abbd_pkg::in_word_t w, input bit gap_ok);
        abbd_pkg::out_word_t r;
        if (gap_ok && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        in_valid = 1'b1;
        in_data = w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (beat_frame_update(w, r))
            frame_results.push_back(r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic abbd_pkg::in_word_t make_word(input logic [15:0] s, input bit last,
                                                     input logic [31:0] t);
        abbd_pkg::in_word_t w;
        w.sample = s; w.frame_last = last; w.now_ms = t;
        return w;
    endfunction

    // Directed rows: sample, last flag, time, and a typed result where obvious.
    typedef struct {
        logic [15:0]         sample;
        bit                  last;
        logic [31:0]         now;
        bit                  typed;
        abbd_pkg::out_word_t want;
    } row_t;

    row_t       rows [$];
    logic [31:0] clock_ms;

    // Sends one frame of random shape, with a loud frame now and then.
    task automatic random_frame(input int loud_pct, output int sent);
        int n;
        bit loud;
        logic [15:0] s;
        n = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 270) : $urandom_range(1, 12);
        loud = $urandom_range(0, 99) < loud_pct;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: s = 16'h0000;
                1: s = 16'h8000;
                2: s = 16'h7FFF;
                default: s = loud ? 16'($urandom) : 16'($urandom_range(0, 300) - 150);
            endcase
            clock_ms = clock_ms + (i == n - 1 ? $urandom_range(0, 700) : 0);
            if ($urandom_range(0, 199) == 0)
                clock_ms = 32'($urandom);
            send_word(make_word(s, i == n - 1, clock_ms), 1'b1);
        end
        sent = n;
    endtask

    initial
    begin
        abbd_pkg::in_word_t  w;
        abbd_pkg::out_word_t none;
        int                  sent;
        in_valid = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_index = abbd_pkg::REG_ATTACK;
        cfg_data = '0; rst_n = 1'b0; stim_done = 1'b0;
        long_stall_req = 1'b0;
        errors = 0; mismatches = 0;
        shadow_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        none = '0;
        none.threshold = 32'd500;
        // Empty frame right after reset: all zero except the offset threshold.
        rows.push_back('{16'h0000, 1'b1, 32'd0, 1'b1, none});
        rows.push_back('{16'h0000, 1'b0, 32'd5, 1'b0, none});
        rows.push_back('{16'h7FFF, 1'b0, 32'd0, 1'b0, none});
        rows.push_back('{16'h8000, 1'b0, 32'd0, 1'b0, none});
        rows.push_back('{16'h8001, 1'b1, 32'd1000, 1'b0, none});
        rows.push_back('{16'h0001, 1'b1, 32'd1500, 1'b0, none});
        rows.push_back('{16'hFFFF, 1'b1, 32'd1550, 1'b0, none});
        rows.push_back('{16'h7FFF, 1'b1, 32'd2100, 1'b0, none});
        rows.push_back('{16'h8000, 1'b1, 32'd4500, 1'b0, none});
        rows.push_back('{16'h7FFF, 1'b1, 32'hFFFF_FFF0, 1'b0, none});
        rows.push_back('{16'h8000, 1'b1, 32'h0000_0100, 1'b0, none});
        rows.push_back('{16'h5555, 1'b1, 32'hFFFF_FFFF, 1'b0, none});
        rows.push_back('{16'hAAAA, 1'b1, 32'h0000_0000, 1'b0, none});
        foreach (rows[i])
        begin
            w = make_word(rows[i].sample, rows[i].last, rows[i].now);
            send_word(w, 1'b0);
            if (rows[i].typed && frame_results.size() != 0)
                frame_results[$] = rows[i].want;
        end
        drain();

        // Overlong frame: nonzero samples past the frame cap are dropped.
        for (int i = 0; i < 300; i++)
            send_word(make_word(i < 256 ? 16'h0100 : 16'h7FFF, i == 299, 32'd9000), 1'b0);

        // The receiver holds off while words keep coming.
        long_stall_req = 1'b1;
        clock_ms = 32'd10000;
        for (int f = 0; f < 6; f++)
            random_frame(50, sent);
        wait (long_stall_done);
        drain();

        // Phases of settings: defaults, extremes, moderate, inverted interval bounds, random.
        clock_ms = 32'd20000;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(abbd_pkg::REG_ATTACK, 24'hFFFF);
                    write_reg(abbd_pkg::REG_RELEASE, 24'hFFFF);
                    write_reg(abbd_pkg::REG_TMULT, 24'hFFFF);
                    write_reg(abbd_pkg::REG_TOFFSET, 24'hFFFFFF);
                    write_reg(abbd_pkg::REG_DEBOUNCE, 24'hFFFF);
                    write_reg(abbd_pkg::REG_IMIN, 24'd1);
                    write_reg(abbd_pkg::REG_IMAX, 24'hFFFF);
                    write_reg(abbd_pkg::REG_TIMEOUT, 24'hFFFF);
                end
                2:
                begin
                    write_reg(abbd_pkg::REG_ATTACK, 24'd0);
                    write_reg(abbd_pkg::REG_RELEASE, 24'd0);
                    write_reg(abbd_pkg::REG_TMULT, 24'd0);
                    write_reg(abbd_pkg::REG_TOFFSET, 24'd0);
                    write_reg(abbd_pkg::REG_DEBOUNCE, 24'd0);
                    write_reg(abbd_pkg::REG_TIMEOUT, 24'd0);
                end
                3:
                begin
                    write_reg(abbd_pkg::REG_ATTACK, 24'hF000);
                    write_reg(abbd_pkg::REG_RELEASE, 24'h2000);
                    write_reg(abbd_pkg::REG_TMULT, 24'd4096);
                    write_reg(abbd_pkg::REG_TOFFSET, 24'd100);
                    write_reg(abbd_pkg::REG_DEBOUNCE, 24'd50);
                    write_reg(abbd_pkg::REG_IMIN, 24'd100);
                    write_reg(abbd_pkg::REG_IMAX, 24'd700);
                    write_reg(abbd_pkg::REG_TIMEOUT, 24'd300);
                end
                4:
                begin
                    write_reg(abbd_pkg::REG_IMIN, 24'd900);
                    write_reg(abbd_pkg::REG_IMAX, 24'd100);
                end
                5:
                begin
                    for (int r = 0; r < 8; r++)
                        write_reg(3'(r), 24'($urandom));
                    write_reg(abbd_pkg::REG_TOFFSET, 24'($urandom_range(0, 2000)));
                    write_reg(abbd_pkg::REG_IMIN, 24'd1);
                    write_reg(abbd_pkg::REG_IMAX, 24'd65535);
                end
                default: ;
            endcase
            for (int n = 0; n < RAND_WORDS / 6; )
            begin
                random_frame(30, sent);
                n = n + sent;
            end
            drain();
        end
        stim_done = 1'b1;
    end

    // Receiver: its own stall pattern, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        long_stall_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall_req && !long_stall_done)
            begin
                out_ready = 1'b0;
                repeat (3000) @(negedge clk);
                long_stall_done = 1'b1;
            end
            case ($urandom_range(0, 3))
                0: out_ready = 1'b1;
                1: out_ready = ($urandom_range(0, 3) != 0);
                2: out_ready = ($urandom_range(0, 1) != 0);
                default: out_ready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Result checker and idle watchdog.
    always @(posedge clk)
    begin
        abbd_pkg::out_word_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (frame_results.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result word %h", out_data);
                end
                else
                begin
                    want = frame_results.pop_front();
                    if (want !== out_data)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: flag %b/%b beat %b/%b bpm %0d/%0d env %0d/%0d thr %0d/%0d",
                                     want.beat_active, out_data.beat_active, want.beat_now,
                                     out_data.beat_now, want.bpm, out_data.bpm,
                                     want.envelope, out_data.envelope,
                                     want.threshold, out_data.threshold);
                    end
                end
            end
        end
        else
            idle_cycles <= 0;
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stim_done)
            begin
                if (frame_results.size() != 0)
                    errors++;
                if (errors == 0)
                    $display("[audio_beat_bpm_detector] OK");
                else
                    $display("[audio_beat_bpm_detector] ERROR");
                $finish;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[audio_beat_bpm_detector] ERROR");
                $finish;
            end
        end
    end
endmodule
